// ----- rtl/bxd_pkg.sv -----
package bxd_pkg;

    // Channel and field widths fixed by the pixel format.
    localparam int PIX_W        = 8;
    localparam int COORD_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int ROW_W        = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int QUOT_STEPS   = 8;
    localparam int STEP_W       = 3;
    localparam int HEIGHT_LIMIT = 4096;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;
    localparam logic [6:0]            RESET_BLOCK_SIZE   = 7'd2;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // What the accumulate stage must do with the pixel it holds.
    typedef struct packed {
        logic valid;
        logic first;
        logic load;
        logic write;
        logic emit;
        logic last;
    } acc_ctl_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

endpackage

// ----- rtl/bxd_if.sv -----
interface bxd_pixel_if;
    import bxd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bxd_result_if;
    import bxd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_red;
    logic [PIX_W-1:0]   out_green;
    logic [PIX_W-1:0]   out_blue;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_x, output out_y, output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_x, input out_y, input frame_last, output ready);
endinterface

interface bxd_cfg_if;
    import bxd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bxd_fifo.sv -----
module bxd_fifo #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [W-1:0]               push_data,
    input  logic                       pop,
    output logic                       pop_valid,
    output logic [W-1:0]               pop_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (level_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign level     = level_reg;
endmodule

// ----- rtl/bxd_front.sv -----
module bxd_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BLOCK = 64,
    parameter int SW        = 20,
    parameter int AWD       = 13,
    parameter int QW        = 83,
    parameter int DEPTH     = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bxd_pixel_if.sink                  pixels,
    bxd_cfg_if.sink                    cfg,
    input  logic [$clog2(DEPTH+1)-1:0] level,
    output logic                       push,
    output logic [QW-1:0]              push_data,
    output logic [AWD-1:0]             area
);
    import bxd_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int BW      = $clog2(MAX_BLOCK);
    localparam int BSW     = $clog2(MAX_BLOCK + 1);
    localparam int ENTRIES = MAX_WIDTH / 2;
    localparam int AW      = $clog2(ENTRIES);
    localparam int XW      = WW + BSW + 1;
    localparam int YW      = HEIGHT_W + BSW + 1;
    localparam int LW      = $clog2(DEPTH + 1);

    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic [6:0]            block_size_reg;
    logic                  restart;

    logic [WW+CFG_DATA_W-1:0] w_ext;
    logic [BSW+6:0]           bs_ext;
    logic [WW-1:0]            w;
    logic [HEIGHT_W-1:0]      h;
    logic [BSW-1:0]           bs;
    logic [AWD-1:0]           area_reg;

    logic [CW-1:0]      col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [BW-1:0]      cib_reg;
    logic [BW-1:0]      rib_reg;
    logic [AW-1:0]      bcol_reg;
    logic [COORD_W-1:0] brow_reg;

    logic          accept;
    logic [XW-1:0] col_start;
    logic [YW-1:0] row_start;
    logic          x_ok, y_ok, x_last, y_last;
    logic          cib_end, rib_end;
    acc_ctl_t      ctl_next;

    acc_ctl_t           s1_reg;
    pixel_t             s1_pix_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [COORD_W-1:0] s1_y_reg;

    logic [3*SW-1:0]    sums_mem [ENTRIES];
    logic [3*SW-1:0]    rdata_reg;
    logic               fwd_reg;
    logic [2:0][SW-1:0] acc_reg;
    logic [2:0][SW-1:0] base;
    logic [2:0][SW-1:0] sum;

    // Configuration registers; any valid write to one of them restarts the image.
    assign cfg.ready = 1'b1;
    assign restart   = cfg.valid &&
                       (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT ||
                        cfg.index == REG_BLOCK_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RESET_IMAGE_WIDTH;
            image_height_reg <= RESET_IMAGE_HEIGHT;
            block_size_reg   <= RESET_BLOCK_SIZE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                REG_BLOCK_SIZE:   block_size_reg   <= cfg.data[6:0];
                default:          ;
            endcase
        end
    end

    // Clamped geometry.
    always_comb
    begin
        w_ext  = (WW + CFG_DATA_W)'(image_width_reg);
        bs_ext = (BSW + 7)'(block_size_reg);
        if (w_ext == '0)
        begin
            w = WW'(1);
        end
        else if (w_ext > (WW + CFG_DATA_W)'(MAX_WIDTH))
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = w_ext[WW-1:0];
        end
        if (image_height_reg == '0)
        begin
            h = HEIGHT_W'(1);
        end
        else if (image_height_reg > HEIGHT_W'(HEIGHT_LIMIT))
        begin
            h = HEIGHT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h = image_height_reg;
        end
        if (bs_ext < (BSW + 7)'(2))
        begin
            bs = BSW'(2);
        end
        else if (bs_ext > (BSW + 7)'(MAX_BLOCK))
        begin
            bs = BSW'(MAX_BLOCK);
        end
        else
        begin
            bs = bs_ext[BSW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= AWD'(bs * bs);
    end

    assign area = area_reg;

    // Classify the pixel at the counters: where its block starts and whether
    // the block lies fully inside the image.
    assign accept    = pixels.valid && pixels.ready;
    assign col_start = XW'(col_reg) - XW'(cib_reg);
    assign row_start = YW'(row_reg) - YW'(rib_reg);
    assign x_ok      = (col_start + XW'(bs)) <= XW'(w);
    assign y_ok      = (row_start + YW'(bs)) <= YW'(h);
    assign x_last    = (col_start + (XW'(bs) << 1)) > XW'(w);
    assign y_last    = (row_start + (YW'(bs) << 1)) > YW'(h);
    assign cib_end   = ((BSW + 1)'(cib_reg) + 1'b1) >= (BSW + 1)'(bs);
    assign rib_end   = ((BSW + 1)'(rib_reg) + 1'b1) >= (BSW + 1)'(bs);

    always_comb
    begin
        ctl_next       = '0;
        ctl_next.valid = accept;
        if (x_ok && y_ok)
        begin
            ctl_next.first = (cib_reg == '0) && (rib_reg == '0);
            ctl_next.load  = (cib_reg == '0) && (rib_reg != '0);
            ctl_next.write = cib_end;
            ctl_next.emit  = cib_end && rib_end;
            ctl_next.last  = x_last && y_last;
        end
    end

    assign pixels.ready = ((LW + 1)'(level) + (LW + 1)'(s1_reg.valid)) < (LW + 1)'(DEPTH);

    // Position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
        end
        else if (accept)
        begin
            if ((XW'(col_reg) + 1'b1) >= XW'(w))
            begin
                col_reg  <= '0;
                cib_reg  <= '0;
                bcol_reg <= '0;
                if ((YW'(row_reg) + 1'b1) >= YW'(h))
                begin
                    row_reg  <= '0;
                    rib_reg  <= '0;
                    brow_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    if (rib_end)
                    begin
                        rib_reg  <= '0;
                        brow_reg <= brow_reg + 1'b1;
                    end
                    else
                    begin
                        rib_reg <= rib_reg + 1'b1;
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                if (cib_end)
                begin
                    cib_reg  <= '0;
                    bcol_reg <= bcol_reg + 1'b1;
                end
                else
                begin
                    cib_reg <= cib_reg + 1'b1;
                end
            end
        end
    end

    // Accumulate stage, registered in the cycle after the request was taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= '{red: pixels.red, green: pixels.green, blue: pixels.blue};
            s1_addr_reg <= bcol_reg;
            s1_y_reg    <= brow_reg;
            rdata_reg   <= sums_mem[bcol_reg];
            // A write landing on the same edge as this read leaves the memory
            // stale; that sum is still in the accumulator.
            fwd_reg     <= s1_reg.valid && s1_reg.write && (s1_addr_reg == bcol_reg);
        end
        if (s1_reg.valid && s1_reg.write)
        begin
            sums_mem[s1_addr_reg] <= sum;
        end
        if (s1_reg.valid && (s1_reg.first || s1_reg.load || s1_reg.write || s1_reg.emit ||
                             !s1_reg.first))
        begin
            acc_reg <= sum;
        end
    end

    always_comb
    begin
        if (s1_reg.first)
        begin
            base = '0;
        end
        else if (s1_reg.load)
        begin
            base = fwd_reg ? acc_reg : rdata_reg;
        end
        else
        begin
            base = acc_reg;
        end
        sum[0] = base[0] + SW'(s1_pix_reg.red);
        sum[1] = base[1] + SW'(s1_pix_reg.green);
        sum[2] = base[2] + SW'(s1_pix_reg.blue);
    end

    // The sums go out in packed order, so the back end finds red at index 0.
    assign push      = s1_reg.valid && s1_reg.emit;
    assign push_data = {sum[2], sum[1], sum[0], COORD_W'(s1_addr_reg), s1_y_reg, s1_reg.last};
endmodule

// ----- rtl/bxd_div.sv -----
module bxd_div #(
    parameter int SW  = 20,
    parameter int AWD = 13,
    parameter int QW  = 83
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           entry_valid,
    input  logic [QW-1:0]  entry_data,
    input  logic [AWD-1:0] area,
    output logic           pop,
    bxd_result_if.source   results
);
    import bxd_pkg::*;

    localparam int DW = AWD + QUOT_STEPS;

    div_state_t state_reg, state_next;

    logic [STEP_W-1:0]       step_reg;
    logic [2:0][DW-1:0]      rem_reg;
    logic [2:0][PIX_W-1:0]   quot_reg;
    logic [COORD_W-1:0]      x_reg, y_reg;
    logic                    last_reg;
    logic [DW-1:0]           divisor;
    logic [2:0]              ge;
    logic [2:0][SW-1:0]      entry_sums;

    assign entry_sums = entry_data[QW-1 -: 3*SW];
    assign divisor    = DW'(area) << step_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ge[c] = rem_reg[c] >= divisor;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (entry_valid)
                begin
                    pop        = 1'b1;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = DIV_HOLD;
                end
            end
            DIV_HOLD:
            begin
                if (results.ready)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One quotient bit per channel and cycle, most significant first.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= DW'(entry_sums[c]);
            end
            step_reg <= STEP_W'(QUOT_STEPS - 1);
            x_reg    <= entry_data[2*COORD_W:COORD_W+1];
            y_reg    <= entry_data[COORD_W:1];
            last_reg <= entry_data[0];
        end
        else if (state_reg == DIV_RUN)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (ge[c])
                begin
                    rem_reg[c] <= rem_reg[c] - divisor;
                end
                quot_reg[c] <= {quot_reg[c][PIX_W-2:0], ge[c]};
            end
            step_reg <= step_reg - 1'b1;
        end
    end

    assign results.valid      = (state_reg == DIV_HOLD);
    assign results.out_red    = quot_reg[0];
    assign results.out_green  = quot_reg[1];
    assign results.out_blue   = quot_reg[2];
    assign results.out_x      = x_reg;
    assign results.out_y      = y_reg;
    assign results.frame_last = last_reg;
endmodule

// ----- rtl/box_average_downscale.sv -----
// Channel    Role   Carries
// pixels     sink   red, green, blue of one input pixel, raster order
// results    source out_red/green/blue, out_x, out_y, frame_last of one block
// cfg        sink   index and data of a configuration register write
//
// Pixels are taken at one per cycle while pixels.ready is high; the sum memory
// is read when a request is taken and written back in the next cycle by the
// accumulate stage. In the divider a block is loaded, runs eight quotient steps,
// then holds its output until taken; a four-entry queue absorbs bursts, and
// pixels stall once its level plus a pixel in the accumulate stage reaches four.
// Reset clears counters and control state at once and sets the configuration
// defaults; the sum memory needs no clearing: every block starts its sums fresh.
module box_average_downscale #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BLOCK = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    bxd_pixel_if.sink    pixels,
    bxd_result_if.source results,
    bxd_cfg_if.sink      cfg
);
    import bxd_pkg::*;

    // Widths of the block sums and of the block area.
    localparam int SW     = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
    localparam int AWD    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int QW     = 3 * SW + 2 * COORD_W + 1;
    localparam int QDEPTH = 4;
    localparam int LW     = $clog2(QDEPTH + 1);

    logic           q_push;
    logic [QW-1:0]  q_push_data;
    logic           q_pop;
    logic           q_valid;
    logic [QW-1:0]  q_data;
    logic [LW-1:0]  q_level;
    logic [AWD-1:0] area;

    // Front: classifies each pixel and accumulates the block sums.
    bxd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK),
        .SW        (SW),
        .AWD       (AWD),
        .QW        (QW),
        .DEPTH     (QDEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .cfg       (cfg),
        .level     (q_level),
        .push      (q_push),
        .push_data (q_push_data),
        .area      (area)
    );

    // Finished block sums wait here for the divider.
    bxd_fifo #(
        .DEPTH (QDEPTH),
        .W     (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .level     (q_level)
    );

    // Back: divides the three sums by the block area.
    bxd_div #(
        .SW  (SW),
        .AWD (AWD),
        .QW  (QW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (q_valid),
        .entry_data  (q_data),
        .area        (area),
        .pop         (q_pop),
        .results     (results)
    );

    // The front only pushes into a queue that has room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_level < LW'(QDEPTH)))
        else $error("block queue overflow");

    // A full queue holds off new pixels.
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == LW'(QDEPTH)) |-> !pixels.ready)
        else $error("pixel taken while block queue full");

    // The divider never takes from an empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("block queue underflow");
endmodule
